// ----- rtl/lfps_pkg.sv -----
// Shared types and constants for the line-follow PID steering core.
// Used by the configuration registers, the steering datapath and the top level.
package lfps_pkg;

  localparam int SENSOR_W = 7;
  localparam int SPEED_W = 7;
  localparam int GAIN_W = 8;
  localparam int ERR_W = 6;
  localparam int SUM_W = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 8'd3;

  localparam logic [SPEED_W-1:0] BASE_RESET = 7'd50;
  localparam logic [SENSOR_W-1:0] SENSORS_ALL = 7'h7f;
  localparam logic [SENSOR_W-1:0] SENSORS_NONE = 7'h00;

  localparam logic signed [SUM_W-1:0] INTEG_HI = 7'sd30;
  localparam logic signed [SUM_W-1:0] INTEG_LO = -7'sd30;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd90;
  localparam logic [SPEED_W-1:0] PIVOT_MAX = 7'd108;
  localparam logic [SPEED_W-1:0] PIVOT_SAT_BASE = 7'd90;
  localparam logic [7:0] DIV5_RECIP = 8'd205;
  localparam int DIV5_SHIFT = 10;

  localparam logic signed [4:0] SENSOR_WEIGHT [SENSOR_W] =
    '{-5'sd7, -5'sd4, -5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd7};

  typedef struct packed {
    logic [SPEED_W-1:0] cruise_speed;
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] error_sum;
    logic signed [ERR_W-1:0] last_error;
  } pid_state_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_cmd;
    logic [SPEED_W-1:0] right_cmd;
    logic               recovering;
  } result_t;

endpackage

// ----- rtl/line_follow_pid_steering_core.sv -----
// The core returns one speed beat per input beat. A beat is held in the input register
// and then lands in the result register; the integral and previous-error registers update
// as the beat moves into the result register, which closes the feedback loop through those
// registers and lets a new beat be taken every clock while the result is not stalled.
// A stalled result beat holds the input register, and a further input beat is taken only
// when the input register can drain.
module line_follow_pid_steering_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] sensor_bits, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] left_cmd, [13:7] right_cmd, [15:14] zero
  output logic        out_tuser,  // [0] recovering
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lfps_pkg::*;

  cfg_t                 cfg;
  pid_state_t           state_r;
  pid_state_t           state_calc;
  result_t              result;
  result_t              out_res_r;
  logic                 in_valid_r;
  logic                 in_valid_nxt;
  logic [SENSOR_W-1:0]  in_bits_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_load;
  logic                 fire;

  lfps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfps_steer_dp u_dp (
    .sensor_bits (in_bits_r),
    .cfg         (cfg),
    .state       (state_r),
    .state_nxt   (state_calc),
    .result      (result)
  );

  assign out_load = !out_valid_r || out_tready;
  assign fire = in_valid_r && out_load;
  assign in_tready = !in_valid_r || out_load;

  assign in_valid_nxt = in_tready ? in_tvalid : in_valid_r;
  assign out_valid_nxt = out_load ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_bits_r <= in_tdata[SENSOR_W-1:0];
    end
    if (fire) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, out_res_r.right_cmd, out_res_r.left_cmd};
  assign out_tuser = out_res_r.recovering;

  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.error_sum <= INTEG_HI) && (state_r.error_sum >= INTEG_LO))
    else $error("integral left its clamp range");

  a_pivot_one_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.recovering) |->
      (out_res_r.left_cmd == '0 || out_res_r.right_cmd == '0))
    else $error("recovery beat drives both wheels");

  a_pid_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.recovering) |->
      (out_res_r.left_cmd <= SPEED_MAX && out_res_r.right_cmd <= SPEED_MAX))
    else $error("steering speed above cap");

  a_state_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("PID state changed without a beat moving");

  a_recovery_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.recovering) |=> $stable(state_r))
    else $error("recovery beat changed PID state");

endmodule

// ----- rtl/lfps_cfg_regs.sv -----
// Configuration register file of the steering core: base speed and the three PID gains.
// Depends on lfps_pkg for register indexes, reset values and the cfg_t bundle.
module lfps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data,
  output lfps_pkg::cfg_t                 cfg
);
  import lfps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASE_SPEED: cfg_nxt.cruise_speed = cfg_data[SPEED_W-1:0];
        CFG_GAIN_PROP:  cfg_nxt.gain_prop = cfg_data[GAIN_W-1:0];
        CFG_GAIN_INTEG: cfg_nxt.gain_integ = cfg_data[GAIN_W-1:0];
        CFG_GAIN_DERIV: cfg_nxt.gain_deriv = cfg_data[GAIN_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cruise_speed <= BASE_RESET;
      cfg_r.gain_prop <= '0;
      cfg_r.gain_integ <= '0;
      cfg_r.gain_deriv <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/lfps_steer_dp.sv -----
// Single-pass steering datapath: position error, clamped PID, wheel speeds and pivot recovery.
// Depends on lfps_pkg; purely combinational, state is held by the top level.
module lfps_steer_dp (
  input  logic [lfps_pkg::SENSOR_W-1:0] sensor_bits,
  input  lfps_pkg::cfg_t                cfg,
  input  lfps_pkg::pid_state_t          state,
  output lfps_pkg::pid_state_t          state_nxt,
  output lfps_pkg::result_t             result
);
  import lfps_pkg::*;

  logic signed [4:0]        err_acc;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W-1:0]  sum_raw;
  logic signed [SUM_W-1:0]  integ;
  logic signed [SUM_W-1:0]  diff;
  logic signed [8:0]        kp_s;
  logic signed [8:0]        ki_s;
  logic signed [8:0]        kd_s;
  logic signed [15:0]       p_term;
  logic signed [15:0]       i_term;
  logic signed [15:0]       d_term;
  logic signed [17:0]       pid;
  logic signed [17:0]       base_s;
  logic signed [17:0]       left_sum;
  logic signed [17:0]       right_sum;
  logic [SPEED_W-1:0]       left_pid;
  logic [SPEED_W-1:0]       right_pid;
  logic [9:0]               base_x6;
  logic [17:0]              pivot_scaled;
  logic [SPEED_W-1:0]       pivot;
  logic                     all_low;
  logic                     all_high;
  logic                     go_left;

  always_comb begin
    err_acc = '0;
    for (int i = 0; i < SENSOR_W; i++) begin
      if (sensor_bits[i]) begin
        err_acc = err_acc + SENSOR_WEIGHT[i];
      end
    end
  end

  assign err = ERR_W'(err_acc);
  assign sum_raw = state.error_sum + SUM_W'(err);
  assign diff = SUM_W'(err) - SUM_W'(state.last_error);

  always_comb begin
    if (sum_raw > INTEG_HI) begin
      integ = INTEG_HI;
    end else if (sum_raw < INTEG_LO) begin
      integ = INTEG_LO;
    end else begin
      integ = sum_raw;
    end
  end

  assign kp_s = $signed({1'b0, cfg.gain_prop});
  assign ki_s = $signed({1'b0, cfg.gain_integ});
  assign kd_s = $signed({1'b0, cfg.gain_deriv});
  assign p_term = 16'(kp_s) * 16'(err);
  assign i_term = 16'(ki_s) * 16'(integ);
  assign d_term = 16'(kd_s) * 16'(diff);
  assign pid = 18'(p_term) + 18'(i_term) + 18'(d_term);

  assign base_s = $signed({11'b0, cfg.cruise_speed});
  assign left_sum = base_s + pid;
  assign right_sum = base_s - pid;

  always_comb begin
    if (left_sum < 18'sd0) begin
      left_pid = '0;
    end else if (left_sum > $signed({11'b0, SPEED_MAX})) begin
      left_pid = SPEED_MAX;
    end else begin
      left_pid = left_sum[SPEED_W-1:0];
    end
    if (right_sum < 18'sd0) begin
      right_pid = '0;
    end else if (right_sum > $signed({11'b0, SPEED_MAX})) begin
      right_pid = SPEED_MAX;
    end else begin
      right_pid = right_sum[SPEED_W-1:0];
    end
  end

  // Division by five is a multiply by 205/1024, exact for all products below 1024.
  assign base_x6 = 10'(cfg.cruise_speed) * 10'd6;
  assign pivot_scaled = 18'(base_x6) * 18'(DIV5_RECIP);
  assign pivot = (cfg.cruise_speed >= PIVOT_SAT_BASE) ? PIVOT_MAX
               : pivot_scaled[DIV5_SHIFT+SPEED_W-1:DIV5_SHIFT];

  assign all_low = (sensor_bits == SENSORS_NONE);
  assign all_high = (sensor_bits == SENSORS_ALL);

  always_comb begin
    if (all_low) begin
      go_left = (state.last_error == '0);
    end else begin
      go_left = (state.last_error > 6'sd0);
    end
  end

  always_comb begin
    if (all_low || all_high) begin
      result.left_cmd = go_left ? pivot : '0;
      result.right_cmd = go_left ? '0 : pivot;
      result.recovering = 1'b1;
      state_nxt = state;
    end else begin
      result.left_cmd = left_pid;
      result.right_cmd = right_pid;
      result.recovering = 1'b0;
      state_nxt.error_sum = integ;
      state_nxt.last_error = err;
    end
  end

endmodule
